/* rtl/ffsa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_pkg
// shared constants for the first-fit segment allocator
// ----------------------------------------------------------------------------
package ffsa_pkg;

	localparam int POOL_WORDS_DEF   = 1024;
	localparam int MAX_SEGMENTS_DEF = 64;

	localparam int OP_W     = 1;
	localparam int SIZE_W   = 11;
	localparam int ADDR_W   = 10;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
	localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NO_SEGMENT = 2'd3;

endpackage

/* rtl/ffsa_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_req_if
// request channel: allocate or free
// ----------------------------------------------------------------------------
interface ffsa_req_if;
	logic                         valid;
	logic                         ready;
	logic [ffsa_pkg::OP_W-1:0]    operation;
	logic [ffsa_pkg::SIZE_W-1:0]  request_size;
	logic [ffsa_pkg::ADDR_W-1:0]  address;

	modport source (output valid, operation, request_size, address, input ready);
	modport sink (input valid, operation, request_size, address, output ready);
endinterface

/* rtl/ffsa_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_rsp_if
// response channel: status, start address and compaction flag
// ----------------------------------------------------------------------------
interface ffsa_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [ffsa_pkg::STATUS_W-1:0]  status;
	logic [ffsa_pkg::ADDR_W-1:0]    start_address;
	logic                           compacted;

	modport source (output valid, status, start_address, compacted, input ready);
	modport sink (input valid, status, start_address, compacted, output ready);
endinterface

/* rtl/ffsa_bank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_bank
// one segment table bank: single write port, registered read port
// ----------------------------------------------------------------------------
module ffsa_bank #(
	parameter int DEPTH = ffsa_pkg::MAX_SEGMENTS_DEF,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/first_fit_segment_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// first-fit allocator over an address-ordered segment table, with merging
// of free neighbours and compaction when the pool is fragmented
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   operation, request_size, address
//  rsp      out  status, start_address, compacted
//
//  a pass reads every segment of the table once; every request but a
//  zero-size allocate runs one pass, and a fragmented allocate up to three
//  (search, compaction, search again). S_DONE loads the response and
//  S_IDLE takes the next request. a pass reads the source bank through
//  the single read port of the table bank, one entry a cycle, and copies
//  it into the other bank.
//  no clearing pass after reset: the first pass reads the reset segment.
//  req is taken only between requests; a held response stalls the next one.
module first_fit_segment_allocator #(
	parameter int POOL_WORDS   = ffsa_pkg::POOL_WORDS_DEF,
	parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ffsa_req_if.sink      req,
	ffsa_rsp_if.source    rsp
);

	localparam int AB  = (POOL_WORDS > 2) ? $clog2(POOL_WORDS) : 1;
	localparam int LB  = $clog2(POOL_WORDS + 1);
	localparam int EW  = AB + LB + 1;
	localparam int IW  = $clog2(MAX_SEGMENTS);
	localparam int CW  = $clog2(MAX_SEGMENTS + 1);
	localparam int SW  = (LB > ffsa_pkg::SIZE_W) ? LB : ffsa_pkg::SIZE_W;
	localparam int CA  = (AB > ffsa_pkg::ADDR_W) ? AB : ffsa_pkg::ADDR_W;

	typedef enum logic [1:0] {S_IDLE, S_PASS, S_FLUSH, S_DONE} state_t;
	typedef enum logic [1:0] {M_ALLOC, M_COMPACT, M_FREE} mode_t;

	state_t state_q;
	mode_t  mode_q;

	logic                           sel_q, init_q;
	logic [CW-1:0]                  count_q, rd_q, wr_q;
	logic                           rv_s1;
	logic [ffsa_pkg::SIZE_W-1:0]    size_q;
	logic [ffsa_pkg::ADDR_W-1:0]    addr_q;
	logic                           found_q, tfull_q, match_q, retry_q, comp_q;
	logic [AB-1:0]                  hit_start_q;
	logic [LB-1:0]                  total_q, next_q;
	logic                           pend_v_q;
	logic [EW-1:0]                  pend_q;
	logic [ffsa_pkg::STATUS_W-1:0]  res_status_q;
	logic [ffsa_pkg::ADDR_W-1:0]    res_where_q;

	logic                           rsp_v_q;
	logic [ffsa_pkg::STATUS_W-1:0]  rsp_status_q;
	logic [ffsa_pkg::ADDR_W-1:0]    rsp_where_q;
	logic                           rsp_comp_q;

	logic [EW-1:0] rdata0, rdata1, ent;
	logic [AB-1:0] e_st;
	logic [LB-1:0] e_ln;
	logic          e_us, used_n, full, hit, split;
	logic          we, pend_ld, pend_add, rd_go;
	logic [EW-1:0] wdata, pend_n;
	logic [CW-1:0] wcount_n;

	// source bank is sel_q, writes go to the other one
	ffsa_bank #(.DEPTH(MAX_SEGMENTS), .WIDTH(EW)) u_bank0 (
		.clk(clk), .we(we && sel_q), .waddr(wr_q[IW-1:0]), .wdata(wdata),
		.raddr(rd_q[IW-1:0]), .rdata(rdata0)
	);
	ffsa_bank #(.DEPTH(MAX_SEGMENTS), .WIDTH(EW)) u_bank1 (
		.clk(clk), .we(we && !sel_q), .waddr(wr_q[IW-1:0]), .wdata(wdata),
		.raddr(rd_q[IW-1:0]), .rdata(rdata1)
	);

	// until the first swap the table is the single reset segment
	assign ent  = init_q ? {AB'(0), LB'(POOL_WORDS), 1'b0} : (sel_q ? rdata1 : rdata0);
	assign e_st = ent[EW-1 -: AB];
	assign e_ln = ent[LB:1];
	assign e_us = ent[0];
	assign full = (count_q == CW'(MAX_SEGMENTS));
	assign rd_go = (state_q == S_PASS) && (rd_q < count_q);

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = rsp_v_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.start_address = rsp_where_q;
	assign rsp.compacted     = rsp_comp_q;

	always_comb begin
		we       = 1'b0;
		wdata    = '0;
		pend_ld  = 1'b0;
		pend_n   = '0;
		pend_add = 1'b0;
		hit      = 1'b0;
		split    = 1'b0;
		used_n   = e_us && (CA'(e_st) != CA'(addr_q));
		if (state_q == S_PASS && rv_s1) begin
			case (mode_q)
				M_ALLOC: begin
					hit   = !found_q && !e_us && (SW'(e_ln) >= SW'(size_q));
					split = SW'(e_ln) != SW'(size_q);
					if (hit) begin
						we    = !(split && full);
						wdata = {e_st, split ? LB'(size_q) : e_ln, 1'b1};
						if (split && !full) begin
							pend_ld = 1'b1;
							pend_n  = {AB'(SW'(e_st) + SW'(size_q)),
								LB'(SW'(e_ln) - SW'(size_q)), 1'b0};
						end
					end else begin
						we = 1'b1;
						if (pend_v_q) begin
							wdata   = pend_q;
							pend_ld = 1'b1;
							pend_n  = ent;
						end else begin
							wdata = ent;
						end
					end
				end
				M_COMPACT: begin
					we    = e_us;
					wdata = {AB'(next_q), e_ln, 1'b1};
				end
				M_FREE: begin
					if (pend_v_q && !pend_q[0] && !used_n) begin
						pend_add = 1'b1;
					end else begin
						we      = pend_v_q;
						wdata   = pend_q;
						pend_ld = 1'b1;
						pend_n  = {e_st, e_ln, used_n};
					end
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end else if (state_q == S_FLUSH) begin
			if (mode_q == M_COMPACT) begin
				// free tail after the packed segments
				we    = (next_q < LB'(POOL_WORDS)) && (wr_q < CW'(MAX_SEGMENTS));
				wdata = {AB'(next_q), LB'(POOL_WORDS) - next_q, 1'b0};
			end else begin
				we    = pend_v_q;
				wdata = pend_q;
			end
		end
		wcount_n = wr_q + CW'(we);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= M_ALLOC;
			sel_q        <= 1'b0;
			init_q       <= 1'b1;
			count_q      <= CW'(1);
			rd_q         <= '0;
			wr_q         <= '0;
			rv_s1        <= 1'b0;
			pend_v_q     <= 1'b0;
			found_q      <= 1'b0;
			tfull_q      <= 1'b0;
			match_q      <= 1'b0;
			retry_q      <= 1'b0;
			comp_q       <= 1'b0;
			rsp_v_q      <= 1'b0;
			rsp_status_q <= ffsa_pkg::ST_OK;
			rsp_where_q  <= '0;
			rsp_comp_q   <= 1'b0;
			res_status_q <= ffsa_pkg::ST_OK;
			res_where_q  <= '0;
			size_q       <= '0;
			addr_q       <= '0;
			hit_start_q  <= '0;
			total_q      <= '0;
			next_q       <= '0;
			pend_q       <= '0;
		end else begin
			if (rsp_v_q && rsp.ready && state_q != S_DONE) begin
				rsp_v_q <= 1'b0;
			end
			rv_s1 <= rd_go;
			if (rd_go) begin
				rd_q <= rd_q + CW'(1);
			end
			if (we && state_q == S_PASS) begin
				wr_q <= wcount_n;
			end
			if (pend_ld) begin
				pend_q   <= pend_n;
				pend_v_q <= 1'b1;
			end else if (pend_add) begin
				pend_q[LB:1] <= pend_q[LB:1] + e_ln;
			end
			if (state_q == S_PASS && rv_s1) begin
				if (mode_q == M_ALLOC) begin
					if (!e_us) begin
						total_q <= total_q + e_ln;
					end
					if (hit) begin
						found_q     <= 1'b1;
						hit_start_q <= e_st;
						tfull_q     <= split && full;
					end
				end
				if (mode_q == M_COMPACT && e_us) begin
					next_q <= next_q + e_ln;
				end
				if (mode_q == M_FREE && CA'(e_st) == CA'(addr_q)) begin
					match_q <= 1'b1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						size_q   <= req.request_size;
						addr_q   <= req.address;
						comp_q   <= 1'b0;
						retry_q  <= 1'b0;
						rd_q     <= '0;
						wr_q     <= '0;
						pend_v_q <= 1'b0;
						found_q  <= 1'b0;
						tfull_q  <= 1'b0;
						match_q  <= 1'b0;
						total_q  <= '0;
						next_q   <= '0;
						if (req.operation == ffsa_pkg::OP_ALLOC &&
							req.request_size == '0) begin
							res_status_q <= ffsa_pkg::ST_NO_SPACE;
							res_where_q  <= '0;
							state_q      <= S_DONE;
						end else begin
							mode_q  <= (req.operation == ffsa_pkg::OP_FREE) ? M_FREE : M_ALLOC;
							state_q <= S_PASS;
						end
					end
				end
				S_PASS: begin
					if (!rd_go && !rv_s1) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					// next pass starts from scratch
					rd_q     <= '0;
					wr_q     <= '0;
					pend_v_q <= 1'b0;
					found_q  <= 1'b0;
					tfull_q  <= 1'b0;
					total_q  <= '0;
					next_q   <= '0;
					res_where_q <= (mode_q == M_ALLOC && found_q && !tfull_q) ?
						ffsa_pkg::ADDR_W'(hit_start_q) : '0;
					state_q  <= S_DONE;
					case (mode_q)
						M_ALLOC: begin
							if (found_q && tfull_q) begin
								res_status_q <= ffsa_pkg::ST_TABLE_FULL;
							end else if (found_q) begin
								sel_q        <= ~sel_q;
								init_q       <= 1'b0;
								count_q      <= wcount_n;
								res_status_q <= ffsa_pkg::ST_OK;
							end else if (!retry_q && SW'(total_q) >= SW'(size_q)) begin
								mode_q  <= M_COMPACT;
								state_q <= S_PASS;
							end else begin
								res_status_q <= ffsa_pkg::ST_NO_SPACE;
							end
						end
						M_COMPACT: begin
							sel_q   <= ~sel_q;
							init_q  <= 1'b0;
							count_q <= wcount_n;
							comp_q  <= 1'b1;
							retry_q <= 1'b1;
							mode_q  <= M_ALLOC;
							state_q <= S_PASS;
						end
						M_FREE: begin
							if (match_q) begin
								sel_q        <= ~sel_q;
								init_q       <= 1'b0;
								count_q      <= wcount_n;
								res_status_q <= ffsa_pkg::ST_OK;
							end else begin
								res_status_q <= ffsa_pkg::ST_NO_SEGMENT;
							end
						end
						default: begin
							res_status_q <= ffsa_pkg::ST_NO_SPACE;
						end
					endcase
				end
				S_DONE: begin
					if (!rsp_v_q || rsp.ready) begin
						rsp_v_q      <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_where_q  <= res_where_q;
						rsp_comp_q   <= comp_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
